/* design/cqm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqm_pkg
// Shared constants and codes for the circular queue with modify.
// ----------------------------------------------------------------------------
package cqm_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W  = 4;
    localparam int DATA_W = 32;

    // Width for head + position and for position vs. occupancy compares
    localparam int SUM_W  = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [1:0]        t_mode;
    typedef logic [1:0]        t_status;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_mode MODE_INSERT  = 2'd0;
    localparam t_mode MODE_DELETE  = 2'd1;
    localparam t_mode MODE_DISPLAY = 2'd2;
    localparam t_mode MODE_MODIFY  = 2'd3;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_EMPTY  = 2'd2;
    localparam t_status ST_BADPOS = 2'd3;

    // Advance a slot index with wraparound at the queue depth
    function automatic t_idx next_slot(input t_idx slot);
        t_idx res;
        if (slot == t_idx'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = slot + t_idx'(1);
        end
        return res;
    endfunction

endpackage

/* design/circular_queue_with_modify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_modify
// Fixed-depth circular FIFO of signed words with insert, delete, display
// and modify-at-position commands, each answered by status-tagged beats.
// ----------------------------------------------------------------------------
// One command beat comes in on i_valid/o_ready; result beats leave on
// o_valid/i_ready through a one-entry output register, and o_last marks the
// final beat of each command. Words live in a single synchronous memory of
// QUEUE_DEPTH entries with a registered read. Insert and every error case
// (full, empty, bad position) answer in the cycle after the command beat.
// Delete and modify first issue the memory read in the command cycle
// (modify writes the new word in the same cycle and gets the old one back),
// then the busy state moves the read word into the output register once it
// is free. Display emits one stored word per cycle while the output side
// does not stall, head first; the memory read port paces it. The block
// works on one command at a time: o_ready is high only while no command is
// in flight and the output register is free or being drained in that cycle.
// ----------------------------------------------------------------------------
module circular_queue_with_modify
    import cqm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Command channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_position,
    // Result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    // Word storage, contents undefined until written
    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Control state
    logic    r_state, n_state;
    t_idx    r_head, n_head;
    t_idx    r_tail, n_tail;
    t_cnt    r_occ, n_occ;
    t_idx    r_slot, n_slot;      // next slot to read during display
    t_cnt    r_left, n_left;      // words still to emit, current one included

    // Output register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;

    // Memory port controls
    logic              mem_we;
    t_idx              mem_wa;
    logic [DATA_W-1:0] mem_wd;
    logic              rd_en;
    t_idx              rd_addr;

    // Output load controls
    logic              load_out;
    t_status           ld_status;
    logic [DATA_W-1:0] ld_data;
    logic              ld_last;

    logic              out_free;
    logic              accept;
    logic              q_full;
    logic              q_empty;
    logic [SUM_W-1:0]  pos_sum;
    logic [SUM_W-1:0]  pos_wrap;
    t_idx              mod_slot;
    logic              pos_bad;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;

    assign q_full  = (r_occ == t_cnt'(QUEUE_DEPTH));
    assign q_empty = (r_occ == '0);

    // Logical position to physical slot; head + position stays below twice
    // the depth whenever the position is in range, so one subtract suffices
    assign pos_sum  = SUM_W'(r_head) + SUM_W'(i_position);
    assign pos_wrap = (pos_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      (pos_sum - SUM_W'(QUEUE_DEPTH)) : pos_sum;
    assign mod_slot = pos_wrap[IDX_W-1:0];
    assign pos_bad  = (CMP_W'(i_position) >= CMP_W'(r_occ));

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_slot    = r_slot;
        n_left    = r_left;
        mem_we    = 1'b0;
        mem_wa    = r_tail;
        mem_wd    = i_value;
        rd_en     = 1'b0;
        rd_addr   = r_head;
        load_out  = 1'b0;
        ld_status = ST_OK;
        ld_data   = '0;
        ld_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_INSERT: begin
                            load_out = 1'b1;
                            if (q_full) begin
                                ld_status = ST_FULL;
                            end else begin
                                mem_we = 1'b1;
                                n_tail = next_slot(r_tail);
                                n_occ  = r_occ + t_cnt'(1);
                            end
                        end
                        MODE_DELETE: begin
                            if (q_empty) begin
                                load_out  = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_head  = next_slot(r_head);
                                n_occ   = r_occ - t_cnt'(1);
                                n_left  = t_cnt'(1);
                                n_state = S_BUSY;
                            end
                        end
                        MODE_DISPLAY: begin
                            if (q_empty) begin
                                load_out  = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_slot  = next_slot(r_head);
                                n_left  = r_occ;
                                n_state = S_BUSY;
                            end
                        end
                        MODE_MODIFY: begin
                            if (q_empty) begin
                                load_out  = 1'b1;
                                ld_status = ST_EMPTY;
                            end else if (pos_bad) begin
                                load_out  = 1'b1;
                                ld_status = ST_BADPOS;
                            end else begin
                                // Read-first port returns the old word
                                rd_en   = 1'b1;
                                rd_addr = mod_slot;
                                mem_we  = 1'b1;
                                mem_wa  = mod_slot;
                                n_left  = t_cnt'(1);
                                n_state = S_BUSY;
                            end
                        end
                        default: begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            S_BUSY: begin
                // Hand the read word over, then fetch the next one if any
                if (out_free) begin
                    load_out = 1'b1;
                    ld_data  = r_rd_data;
                    ld_last  = (r_left == t_cnt'(1));
                    if (r_left == t_cnt'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_slot;
                        n_slot  = next_slot(r_slot);
                        n_left  = r_left - t_cnt'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Storage and its registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_slot      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_slot  <= n_slot;
            r_left  <= n_left;
            // Hold the beat until taken, drop it once the sink takes it
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= ld_status;
            r_out_data   <= ld_data;
            r_out_last   <= ld_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_data   = r_out_data;
    assign o_last   = r_out_last;

endmodule

/* dv/cqm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqm_checker
// Watches the command and result channels of the circular queue, keeps its
// own copy of the ring, and compares every result beat with the prediction.
// ----------------------------------------------------------------------------
module cqm_checker
    import cqm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Command channel, observed
    input  logic                     i_cmd_valid,
    input  logic                     i_cmd_ready,
    input  logic [1:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_position,
    // Result channel, observed
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic [1:0]               i_status,
    input  logic signed [DATA_W-1:0] i_data,
    input  logic                     i_last,
    // Bookkeeping for the top
    output int                       o_err_cnt,
    output int                       o_pending,
    output int                       o_level,
    output int                       o_beat_cnt
);

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } t_answer;

    t_answer                  answers_due[$];
    logic signed [DATA_W-1:0] ring_words [QUEUE_DEPTH];
    int                       head_slot;
    int                       tail_slot;
    int                       word_count;

    task automatic queue_answer(input t_status s, input logic signed [DATA_W-1:0] d,
                                input logic l);
        t_answer a;
        a.status = s;
        a.data   = d;
        a.last   = l;
        answers_due.push_back(a);
    endtask

    // Apply one command beat to the shadow ring and queue its answers
    task automatic apply_command(input t_mode m, input logic signed [DATA_W-1:0] v,
                                 input logic [POS_W-1:0] p);
        int slot;
        case (m)
            MODE_INSERT: begin
                if (word_count >= QUEUE_DEPTH) begin
                    queue_answer(ST_FULL, '0, 1'b1);
                end else begin
                    ring_words[tail_slot] = v;
                    tail_slot  = (tail_slot + 1) % QUEUE_DEPTH;
                    word_count = word_count + 1;
                    queue_answer(ST_OK, '0, 1'b1);
                end
            end
            MODE_DELETE: begin
                if (word_count == 0) begin
                    queue_answer(ST_EMPTY, '0, 1'b1);
                end else begin
                    queue_answer(ST_OK, ring_words[head_slot], 1'b1);
                    head_slot  = (head_slot + 1) % QUEUE_DEPTH;
                    word_count = word_count - 1;
                end
            end
            MODE_DISPLAY: begin
                if (word_count == 0) begin
                    queue_answer(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int k = 0; k < word_count; k++) begin
                        slot = (head_slot + k) % QUEUE_DEPTH;
                        queue_answer(ST_OK, ring_words[slot], k == word_count - 1);
                    end
                end
            end
            MODE_MODIFY: begin
                if (word_count == 0) begin
                    queue_answer(ST_EMPTY, '0, 1'b1);
                end else if (int'(p) >= word_count) begin
                    queue_answer(ST_BADPOS, '0, 1'b1);
                end else begin
                    slot = (head_slot + int'(p)) % QUEUE_DEPTH;
                    queue_answer(ST_OK, ring_words[slot], 1'b1);
                    ring_words[slot] = v;
                end
            end
        endcase
    endtask

    task automatic count_mismatch(input string what);
        o_err_cnt = o_err_cnt + 1;
        if (o_err_cnt <= 10) begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    // Compare one result beat with the oldest answer still due
    task automatic check_beat();
        t_answer want;
        if (answers_due.size() == 0) begin
            count_mismatch($sformatf("unexpected beat: status %0d data %0d last %0b",
                                     i_status, i_data, i_last));
        end else begin
            want = answers_due.pop_front();
            if (i_status !== want.status || i_data !== want.data
                    || i_last !== want.last) begin
                count_mismatch($sformatf({"mismatch: status exp %0d got %0d, ",
                    "data exp %0d got %0d, last exp %0b got %0b"},
                    want.status, i_status, want.data, i_data, want.last, i_last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            answers_due.delete();
            head_slot  = 0;
            tail_slot  = 0;
            word_count = 0;
        end else begin
            // A beat leaving in the same cycle always belongs to an older command
            if (i_res_valid && i_res_ready) begin
                o_beat_cnt = o_beat_cnt + 1;
                check_beat();
            end
            if (i_cmd_valid && i_cmd_ready) begin
                apply_command(t_mode'(i_mode), i_value, i_position);
            end
        end
        o_pending = answers_due.size();
        o_level   = word_count;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete, display and modify commands into the circular queue
// with bursty command traffic and a stalling result side; a separate checker
// predicts every result beat and reports mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import cqm_pkg::*;

    localparam int RAND_CMDS      = 434;
    localparam int HOLD_AT        = 150;    // commands sent before the long hold-off
    localparam int LONG_HOLD      = 300;    // cycles the result side stays stalled
    localparam int TAIL_CYCLES    = 10;     // settle time after the last beat
    localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cmd_valid;
    logic                     cmd_ready;
    logic [1:0]               cmd_mode;
    logic signed [DATA_W-1:0] cmd_value;
    logic [POS_W-1:0]         cmd_pos;
    logic                     res_valid;
    logic                     res_ready;
    logic [1:0]               res_status;
    logic signed [DATA_W-1:0] res_data;
    logic                     res_last;

    int err_cnt;
    int pending;
    int level;
    int beat_cnt;
    int sent_cnt = 0;
    int mode_cnt [4] = '{0, 0, 0, 0};
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    circular_queue_with_modify i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (cmd_valid),
        .o_ready    (cmd_ready),
        .i_mode     (cmd_mode),
        .i_value    (cmd_value),
        .i_position (cmd_pos),
        .o_valid    (res_valid),
        .i_ready    (res_ready),
        .o_status   (res_status),
        .o_data     (res_data),
        .o_last     (res_last)
    );

    cqm_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .i_mode      (cmd_mode),
        .i_value     (cmd_value),
        .i_position  (cmd_pos),
        .i_res_valid (res_valid),
        .i_res_ready (res_ready),
        .i_status    (res_status),
        .i_data      (res_data),
        .i_last      (res_last),
        .o_err_cnt   (err_cnt),
        .o_pending   (pending),
        .o_level     (level),
        .o_beat_cnt  (beat_cnt)
    );

    // Favor the extreme words so sign and carry corners show up often
    function automatic logic signed [DATA_W-1:0] pick_word();
        logic signed [DATA_W-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = 32'sh8000_0000;
            1:       w = 32'sh7fff_ffff;
            2:       w = '0;
            3:       w = -32'sd1;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Offer one command beat and hold it until the queue takes it.
    // Called at a falling edge, returns at the falling edge after acceptance
    // with valid still high, so back-to-back beats keep valid up.
    task automatic send_cmd(input t_mode m, input logic signed [DATA_W-1:0] v,
                            input logic [POS_W-1:0] p);
        cmd_mode  = m;
        cmd_value = v;
        cmd_pos   = p;
        cmd_valid = 1'b1;
        do @(posedge clk); while (!cmd_ready);
        sent_cnt    = sent_cnt + 1;
        mode_cnt[m] = mode_cnt[m] + 1;
        @(negedge clk);
    endtask

    // Drop valid for a gap; scramble the payload so it is never relied on
    task automatic idle_for(input int cycles);
        cmd_valid = 1'b0;
        cmd_mode  = t_mode'($urandom);
        cmd_value = $urandom;
        cmd_pos   = POS_W'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    // Pick a mode from the phase bias: fill, drain or mixed
    function automatic t_mode pick_mode(input int phase);
        int    r;
        t_mode m;
        r = $urandom_range(0, 99);
        case (phase)
            0:       m = (r < 60) ? MODE_INSERT : (r < 70) ? MODE_DELETE :
                         (r < 80) ? MODE_DISPLAY : MODE_MODIFY;
            1:       m = (r < 15) ? MODE_INSERT : (r < 70) ? MODE_DELETE :
                         (r < 80) ? MODE_DISPLAY : MODE_MODIFY;
            default: m = (r < 35) ? MODE_INSERT : (r < 65) ? MODE_DELETE :
                         (r < 75) ? MODE_DISPLAY : MODE_MODIFY;
        endcase
        return m;
    endfunction

    // Result side: stall with a density that is picked anew for each random
    // stretch, and once, mid-run, hold off long enough that the queue backs up
    // and the command side has to wait.
    initial begin
        int density;
        int stretch;
        bit hold_done;
        density   = 100;
        stretch   = 0;
        hold_done = 1'b0;
        res_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && sent_cnt >= HOLD_AT) begin
                res_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                if (stretch == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    density = 100;
                        2:       density = 75;
                        3:       density = 40;
                        default: density = 15;
                    endcase
                    stretch = $urandom_range(30, 150);
                end
                stretch   = stretch - 1;
                res_ready = ($urandom_range(1, 100) <= density);
            end
        end
    end

    // Give up when neither channel moves a beat for too long
    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d beats still due",
                     quiet_cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int    sent_rand;
        int    burst_left;
        int    phase;
        int    gap;
        t_mode m;
        logic [POS_W-1:0] p;

        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_mode  = MODE_INSERT;
        cmd_value = '0;
        cmd_pos   = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: delete, display and modify on an empty queue first
        send_cmd(MODE_DELETE,  32'sd5, 4'd0);
        send_cmd(MODE_DISPLAY, 32'sd5, 4'd0);
        send_cmd(MODE_MODIFY,  32'sd5, 4'd0);

        // Extreme words, then modify inside and just past the occupancy
        send_cmd(MODE_INSERT, 32'sh8000_0000, 4'd15);
        send_cmd(MODE_INSERT, 32'sh7fff_ffff, 4'd0);
        send_cmd(MODE_INSERT, '0,             4'd0);
        send_cmd(MODE_INSERT, -32'sd1,        4'd0);
        send_cmd(MODE_MODIFY, 32'sh1234_5678, 4'd0);
        send_cmd(MODE_MODIFY, 32'sh8000_0000, 4'd3);
        send_cmd(MODE_MODIFY, 32'sh7fff_ffff, 4'd4);
        send_cmd(MODE_DISPLAY, '0, 4'd0);

        // Fill to the brim, insert on full, modify the newest word, show all
        repeat (QUEUE_DEPTH - 4) send_cmd(MODE_INSERT, pick_word(), POS_W'($urandom));
        send_cmd(MODE_INSERT, pick_word(), 4'd0);
        send_cmd(MODE_MODIFY, pick_word(), 4'd15);
        send_cmd(MODE_DISPLAY, '0, 4'd0);

        // Random: bursts with gaps, biased phases so the queue swings between
        // empty and full and the pointers wrap many times
        sent_rand  = 0;
        burst_left = $urandom_range(1, 16);
        phase      = 2;
        while (sent_rand < RAND_CMDS) begin
            if (sent_rand % 48 == 0) begin
                phase = $urandom_range(0, 2);
            end
            m = pick_mode(phase);
            // Aim modify mostly at live words, sometimes anywhere
            if (level > 0 && $urandom_range(0, 3) != 0) begin
                p = POS_W'($urandom_range(0, level - 1));
            end else begin
                p = POS_W'($urandom_range(0, 15));
            end
            send_cmd(m, pick_word(), p);
            sent_rand = sent_rand + 1;

            burst_left = burst_left - 1;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    idle_for(gap);
                end
                burst_left = $urandom_range(1, 16);
            end

            // Once midway, hold the command side until every beat is back
            if (sent_rand == RAND_CMDS / 2) begin
                idle_for(1);
                while (pending != 0) @(negedge clk);
            end
        end

        // Drain and let the block settle
        idle_for(1);
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d commands (%0d insert, %0d delete, %0d display, %0d modify)",
                 sent_cnt, mode_cnt[MODE_INSERT], mode_cnt[MODE_DELETE],
                 mode_cnt[MODE_DISPLAY], mode_cnt[MODE_MODIFY]);
        $display("and %0d result beats, with a long result stall and a mid-run drain.",
                 beat_cnt);
        if (err_cnt == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d result beats never arrived", err_cnt, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
